@@ hw/rtl/pvp_pkg.sv @@
// ----------------------------------------------------------------------------
// pvp_pkg
// Shared types, constants and tables of the pH PID valve pulse planner.
// ----------------------------------------------------------------------------
package pvp_pkg;

  // pulse search
  localparam int MAX_PULSES = 6;
  localparam int N_W        = $clog2(MAX_PULSES + 1);

  // field widths
  localparam int PH_W       = 11;
  localparam int GAIN_W     = 16;
  localparam int CYC_W      = 4;
  localparam int PCT_W      = 14;
  localparam int PID_W      = 13;
  localparam int MS_W       = 14;
  localparam int CNT_OUT_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // datapath widths
  localparam int ERR_W   = PH_W + 1;
  localparam int PROD_W  = GAIN_W + 1 + ERR_W;
  localparam int ISUM_W  = 32;
  localparam int ACC_W   = 34;
  localparam int MAG_W   = 22;
  localparam int CSO_W   = 17;

  // reset values and limits
  localparam int PH_RESET      = 700;
  localparam int GAIN_P_RESET  = 5000;
  localparam int GAIN_I_RESET  = 150;
  localparam int GAIN_D_RESET  = 1000;
  localparam int CYC_RESET     = 3;
  localparam int CYC_MIN       = 3;
  localparam int CYC_MAX       = 10;
  localparam int PCT_MIN       = 500;
  localparam int PCT_MAX       = 9500;
  localparam int PID_LIMIT     = 3000000;
  localparam int PACK_MIN_MS   = 250;
  localparam int ONE_MIN_MS    = 100;
  localparam int MS_PER_SEC    = 1000;

  // reciprocal multiply: floor(x / n) = (x * ceil(2^SHIFT / n)) >> SHIFT
  localparam int RECIP_SHIFT   = 20;
  localparam int RECIP_W       = 21;
  localparam int RECIP_ARG_W   = 5;
  localparam int RECIP_TEN     = 104858;
  localparam int RPROD_W       = CSO_W + RECIP_W;
  localparam int KILO_SHIFT    = 32;
  localparam int KILO_W        = 23;
  localparam int RECIP_KILO    = 4294968;
  localparam int DPROD_W       = MAG_W + KILO_W;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_PID   = 2'd2,
    OP_DOSE  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT = 3'd0,
    REG_GAIN_P   = 3'd1,
    REG_GAIN_I   = 3'd2,
    REG_GAIN_D   = 3'd3,
    REG_CYCLE    = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    MUL_GI = 2'd0,
    MUL_GP = 2'd1,
    MUL_GD = 2'd2
  } mul_sel_t;

  typedef enum logic [1:0] {
    REC_IMP  = 2'd0,
    REC_HIGH = 2'd1,
    REC_LOW  = 2'd2
  } rec_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PID_INT,
    ST_PID_ADDP,
    ST_PID_ADDD,
    ST_PID_DIV,
    ST_PID_OUT,
    ST_DOS_OPEN,
    ST_DOS_MUL,
    ST_DOS_REC,
    ST_DOS_IMP,
    ST_SRCH_H,
    ST_SRCH_HN,
    ST_SRCH_REM,
    ST_SRCH_LM,
    ST_SRCH_CHK,
    ST_FALLBACK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     latch;
    logic     apply_simple;
    logic     mul_load;
    mul_sel_t mul_sel;
    logic     integ_update;
    logic     acc_add;
    logic     prev_load;
    logic     div_load;
    logic     pid_load;
    logic     open_update;
    logic     cso_load;
    logic     rec_load;
    rec_sel_t rec_sel;
    logic     imp_load;
    logic     n_init;
    logic     n_dec;
    logic     high_load;
    logic     rem_load;
    logic     low_load;
    logic     fallback;
    logic     out_load;
  } pvp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic enable;
    logic imp_ok;
    logic high_ok;
    logic low_ok;
    logic n_last;
    logic out_free;
  } pvp_status_t;

  // ceil(2^20 / n) for the pulse counts
  function automatic logic [RECIP_W-1:0] recip_n(input logic [RECIP_ARG_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      5'd1:    r = 21'd1048576;
      5'd2:    r = 21'd524288;
      5'd3:    r = 21'd349526;
      5'd4:    r = 21'd262144;
      5'd5:    r = 21'd209716;
      5'd6:    r = 21'd174763;
      5'd7:    r = 21'd149797;
      5'd8:    r = 21'd131072;
      5'd9:    r = 21'd116509;
      5'd10:   r = 21'd104858;
      5'd11:   r = 21'd95326;
      5'd12:   r = 21'd87382;
      5'd13:   r = 21'd80660;
      5'd14:   r = 21'd74899;
      5'd15:   r = 21'd69906;
      5'd16:   r = 21'd65536;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/pvp_ctrl.sv @@
// ----------------------------------------------------------------------------
// pvp_ctrl
// Sequencer: steps the datapath through start/stop, PID and dosing work.
// ----------------------------------------------------------------------------
module pvp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pvp_pkg::pvp_status_t status,
  output pvp_pkg::pvp_cmd_t    cmd
);

  pvp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pvp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pvp_pkg::ST_IDLE: begin
        if (in_valid) state_next = pvp_pkg::ST_DISPATCH;
      end
      pvp_pkg::ST_DISPATCH: begin
        if (status.op == pvp_pkg::OP_PID && status.enable) begin
          state_next = pvp_pkg::ST_PID_INT;
        end else if (status.op == pvp_pkg::OP_DOSE && status.enable) begin
          state_next = pvp_pkg::ST_DOS_OPEN;
        end else begin
          state_next = pvp_pkg::ST_DONE;
        end
      end
      pvp_pkg::ST_PID_INT:  state_next = pvp_pkg::ST_PID_ADDP;
      pvp_pkg::ST_PID_ADDP: state_next = pvp_pkg::ST_PID_ADDD;
      pvp_pkg::ST_PID_ADDD: state_next = pvp_pkg::ST_PID_DIV;
      pvp_pkg::ST_PID_DIV:  state_next = pvp_pkg::ST_PID_OUT;
      pvp_pkg::ST_PID_OUT:  state_next = pvp_pkg::ST_DONE;
      pvp_pkg::ST_DOS_OPEN: state_next = pvp_pkg::ST_DOS_MUL;
      pvp_pkg::ST_DOS_MUL:  state_next = pvp_pkg::ST_DOS_REC;
      pvp_pkg::ST_DOS_REC:  state_next = pvp_pkg::ST_DOS_IMP;
      pvp_pkg::ST_DOS_IMP: begin
        state_next = status.imp_ok ? pvp_pkg::ST_SRCH_H : pvp_pkg::ST_DONE;
      end
      pvp_pkg::ST_SRCH_H:  state_next = pvp_pkg::ST_SRCH_HN;
      pvp_pkg::ST_SRCH_HN: state_next = pvp_pkg::ST_SRCH_REM;
      pvp_pkg::ST_SRCH_REM: begin
        if (status.high_ok) begin
          state_next = pvp_pkg::ST_SRCH_LM;
        end else if (status.n_last) begin
          state_next = pvp_pkg::ST_FALLBACK;
        end else begin
          state_next = pvp_pkg::ST_SRCH_H;
        end
      end
      pvp_pkg::ST_SRCH_LM: state_next = pvp_pkg::ST_SRCH_CHK;
      pvp_pkg::ST_SRCH_CHK: begin
        if (status.low_ok) begin
          state_next = pvp_pkg::ST_DONE;
        end else if (status.n_last) begin
          state_next = pvp_pkg::ST_FALLBACK;
        end else begin
          state_next = pvp_pkg::ST_SRCH_H;
        end
      end
      pvp_pkg::ST_FALLBACK: state_next = pvp_pkg::ST_DONE;
      pvp_pkg::ST_DONE: begin
        if (status.out_free) state_next = pvp_pkg::ST_IDLE;
      end
      default: state_next = pvp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.mul_sel = pvp_pkg::MUL_GI;
    cmd.rec_sel = pvp_pkg::REC_IMP;
    in_ready = 1'b0;
    case (state)
      pvp_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      pvp_pkg::ST_DISPATCH: begin
        cmd.apply_simple = (status.op == pvp_pkg::OP_START) ||
                           (status.op == pvp_pkg::OP_STOP);
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = pvp_pkg::MUL_GI;
      end
      pvp_pkg::ST_PID_INT: begin
        cmd.integ_update = 1'b1;
        cmd.mul_load     = 1'b1;
        cmd.mul_sel      = pvp_pkg::MUL_GP;
      end
      pvp_pkg::ST_PID_ADDP: begin
        cmd.acc_add  = 1'b1;
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = pvp_pkg::MUL_GD;
      end
      pvp_pkg::ST_PID_ADDD: begin
        cmd.acc_add   = 1'b1;
        cmd.prev_load = 1'b1;
      end
      pvp_pkg::ST_PID_DIV: cmd.div_load = 1'b1;
      pvp_pkg::ST_PID_OUT: cmd.pid_load = 1'b1;
      pvp_pkg::ST_DOS_OPEN: cmd.open_update = 1'b1;
      pvp_pkg::ST_DOS_MUL:  cmd.cso_load = 1'b1;
      pvp_pkg::ST_DOS_REC: begin
        cmd.rec_load = 1'b1;
        cmd.rec_sel  = pvp_pkg::REC_IMP;
      end
      pvp_pkg::ST_DOS_IMP: begin
        cmd.imp_load = 1'b1;
        cmd.n_init   = 1'b1;
      end
      pvp_pkg::ST_SRCH_H: begin
        cmd.rec_load = 1'b1;
        cmd.rec_sel  = pvp_pkg::REC_HIGH;
      end
      pvp_pkg::ST_SRCH_HN: cmd.high_load = 1'b1;
      pvp_pkg::ST_SRCH_REM: begin
        cmd.rem_load = status.high_ok;
        cmd.n_dec    = !status.high_ok && !status.n_last;
      end
      pvp_pkg::ST_SRCH_LM: begin
        cmd.rec_load = 1'b1;
        cmd.rec_sel  = pvp_pkg::REC_LOW;
      end
      pvp_pkg::ST_SRCH_CHK: begin
        cmd.low_load = status.low_ok;
        cmd.n_dec    = !status.low_ok && !status.n_last;
      end
      pvp_pkg::ST_FALLBACK: cmd.fallback = 1'b1;
      pvp_pkg::ST_DONE: cmd.out_load = status.out_free;
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/pvp_dp.sv @@
// ----------------------------------------------------------------------------
// pvp_dp
// Datapath: config registers, regulator state, PID and pulse arithmetic,
// and the output register.
// ----------------------------------------------------------------------------
module pvp_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  pvp_pkg::pvp_cmd_t                 cmd,
  output pvp_pkg::pvp_status_t              status,
  input  logic                              cfg_we,
  input  logic [pvp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pvp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [1:0]                        op,
  input  logic [pvp_pkg::PH_W-1:0]          measured_ph,
  input  logic [pvp_pkg::PCT_W-1:0]         start_percent,
  input  logic                              regulate_enable,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [pvp_pkg::PID_W-1:0]  pid_value,
  output logic [pvp_pkg::PCT_W-1:0]         valve_percent,
  output logic [pvp_pkg::MS_W-1:0]          impulse_ms,
  output logic [pvp_pkg::CNT_OUT_W-1:0]     pulse_count,
  output logic [pvp_pkg::MS_W-1:0]          pulse_high_ms,
  output logic [pvp_pkg::MS_W-1:0]          pulse_low_ms
);

  localparam logic signed [pvp_pkg::ACC_W-1:0] ISUM_HI = 34'sd2147483647;
  localparam logic signed [pvp_pkg::ACC_W-1:0] ISUM_LO = -34'sd2147483648;
  localparam logic signed [pvp_pkg::ACC_W-1:0] LIM_HI  = 34'(pvp_pkg::PID_LIMIT);
  localparam logic signed [pvp_pkg::ACC_W-1:0] LIM_LO  = -34'(pvp_pkg::PID_LIMIT);

  // configuration
  logic [pvp_pkg::PH_W-1:0]   setpoint;
  logic [pvp_pkg::GAIN_W-1:0] gain_p, gain_i, gain_d;
  logic [pvp_pkg::CYC_W-1:0]  cycle_s;
  logic [pvp_pkg::CYC_W-1:0]  cyc_wr;

  // regulator state
  logic signed [pvp_pkg::ISUM_W-1:0] isum;
  logic [pvp_pkg::PH_W-1:0]          prev_ph;
  logic [pvp_pkg::PCT_W-1:0]         opening;
  logic signed [pvp_pkg::PID_W-1:0]  pid_out;

  // latched item
  pvp_pkg::op_t              op_q;
  logic [pvp_pkg::PH_W-1:0]  meas_q;
  logic [pvp_pkg::PCT_W-1:0] start_q;
  logic                      en_q;

  // PID arithmetic
  logic signed [pvp_pkg::ERR_W-1:0]  err, dph, mul_arg;
  logic [pvp_pkg::GAIN_W-1:0]        mul_gain;
  logic signed [pvp_pkg::PROD_W-1:0] prod, prod_next;
  logic signed [pvp_pkg::ACC_W-1:0]  acc, isum_wide, acc_clamp;
  logic signed [pvp_pkg::ISUM_W-1:0] isum_sat;
  logic [pvp_pkg::MAG_W-1:0]         mag;
  logic [pvp_pkg::DPROD_W-1:0]       dprod;
  logic                              acc_neg;
  logic [pvp_pkg::PID_W-1:0]         quot;

  // dosing arithmetic
  logic signed [pvp_pkg::PCT_W+1:0]  open_sum;
  logic [pvp_pkg::CSO_W-1:0]         cso, rec_a;
  logic [pvp_pkg::RECIP_W-1:0]       rec_m;
  logic [pvp_pkg::RPROD_W-1:0]       rprod;
  logic [pvp_pkg::RPROD_W-pvp_pkg::RECIP_SHIFT-1:0] rec_q;
  logic [pvp_pkg::MS_W-1:0]          span, impulse, high, low, rem;
  logic [pvp_pkg::MS_W+pvp_pkg::N_W-1:0] high_n;
  logic [pvp_pkg::N_W-1:0]           n, count;

  // output register
  logic signed [pvp_pkg::PID_W-1:0]  out_pid;
  logic [pvp_pkg::PCT_W-1:0]         out_pct;
  logic [pvp_pkg::MS_W-1:0]          out_imp, out_high, out_low;
  logic [pvp_pkg::CNT_OUT_W-1:0]     out_cnt;

  // ---- configuration port ----
  always_comb begin
    cyc_wr = cfg_data[pvp_pkg::CYC_W-1:0];
    if (cyc_wr < 4'(pvp_pkg::CYC_MIN)) cyc_wr = 4'(pvp_pkg::CYC_MIN);
    else if (cyc_wr > 4'(pvp_pkg::CYC_MAX)) cyc_wr = 4'(pvp_pkg::CYC_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= 11'(pvp_pkg::PH_RESET);
      gain_p   <= 16'(pvp_pkg::GAIN_P_RESET);
      gain_i   <= 16'(pvp_pkg::GAIN_I_RESET);
      gain_d   <= 16'(pvp_pkg::GAIN_D_RESET);
      cycle_s  <= 4'(pvp_pkg::CYC_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        pvp_pkg::REG_SETPOINT: setpoint <= cfg_data[pvp_pkg::PH_W-1:0];
        pvp_pkg::REG_GAIN_P:   gain_p   <= cfg_data;
        pvp_pkg::REG_GAIN_I:   gain_i   <= cfg_data;
        pvp_pkg::REG_GAIN_D:   gain_d   <= cfg_data;
        pvp_pkg::REG_CYCLE:    cycle_s  <= cyc_wr;
        default: ;
      endcase
    end
  end

  // ---- combinational arithmetic ----
  always_comb begin
    err = $signed({1'b0, setpoint}) - $signed({1'b0, meas_q});
    dph = $signed({1'b0, meas_q}) - $signed({1'b0, prev_ph});
    case (cmd.mul_sel)
      pvp_pkg::MUL_GI: begin mul_gain = gain_i; mul_arg = err; end
      pvp_pkg::MUL_GP: begin mul_gain = gain_p; mul_arg = err; end
      pvp_pkg::MUL_GD: begin mul_gain = gain_d; mul_arg = dph; end
      default:         begin mul_gain = gain_i; mul_arg = err; end
    endcase
    prod_next = $signed({1'b0, mul_gain}) * mul_arg;

    // integral with saturation to 32 bits
    isum_wide = 34'(prod) + 34'(isum);
    if (isum_wide > ISUM_HI)      isum_sat = 32'sh7FFF_FFFF;
    else if (isum_wide < ISUM_LO) isum_sat = 32'sh8000_0000;
    else                          isum_sat = isum_wide[pvp_pkg::ISUM_W-1:0];

    if (acc > LIM_HI)      acc_clamp = LIM_HI;
    else if (acc < LIM_LO) acc_clamp = LIM_LO;
    else                   acc_clamp = acc;
    mag  = acc_clamp[pvp_pkg::ACC_W-1] ? pvp_pkg::MAG_W'(-acc_clamp)
                                       : pvp_pkg::MAG_W'(acc_clamp);
    quot = dprod[pvp_pkg::KILO_SHIFT +: pvp_pkg::PID_W];

    open_sum = $signed({2'b00, opening}) + 16'(pid_out);

    span = 14'(14'(cycle_s) * 14'(pvp_pkg::MS_PER_SEC) - 14'(pvp_pkg::ONE_MIN_MS));

    case (cmd.rec_sel)
      pvp_pkg::REC_IMP: begin
        rec_a = cso;
        rec_m = 21'(pvp_pkg::RECIP_TEN);
      end
      pvp_pkg::REC_HIGH: begin
        rec_a = 17'(impulse);
        rec_m = pvp_pkg::recip_n(5'(n));
      end
      pvp_pkg::REC_LOW: begin
        rec_a = 17'(rem);
        rec_m = pvp_pkg::recip_n(5'(n));
      end
      default: begin
        rec_a = cso;
        rec_m = 21'(pvp_pkg::RECIP_TEN);
      end
    endcase
    rec_q  = rprod[pvp_pkg::RPROD_W-1:pvp_pkg::RECIP_SHIFT];
    high_n = (pvp_pkg::MS_W + pvp_pkg::N_W)'(high) * (pvp_pkg::MS_W + pvp_pkg::N_W)'(n);
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      isum    <= '0;
      prev_ph <= 11'(pvp_pkg::PH_RESET);
      opening <= 14'(pvp_pkg::PCT_MIN);
      pid_out <= '0;
    end else begin
      if (cmd.apply_simple) begin
        pid_out <= '0;
        isum    <= '0;
        if (op_q == pvp_pkg::OP_START) begin
          prev_ph <= 11'(pvp_pkg::PH_RESET);
          if (start_q < 14'(pvp_pkg::PCT_MIN) || start_q > 14'(pvp_pkg::PCT_MAX)) begin
            opening <= 14'(pvp_pkg::PCT_MIN);
          end else begin
            opening <= start_q;
          end
        end else begin
          opening <= 14'(pvp_pkg::PCT_MIN);
        end
      end
      if (cmd.integ_update) isum <= isum_sat;
      if (cmd.prev_load) prev_ph <= meas_q;
      if (cmd.pid_load) pid_out <= acc_neg ? $signed(quot) : -$signed(quot);
      if (cmd.open_update) begin
        if (open_sum < 16'sd500) opening <= 14'(pvp_pkg::PCT_MIN);
        else if (open_sum > 16'sd9500) opening <= 14'(pvp_pkg::PCT_MAX);
        else opening <= open_sum[pvp_pkg::PCT_W-1:0];
      end
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= pvp_pkg::op_t'(op);
      meas_q  <= measured_ph;
      start_q <= start_percent;
      en_q    <= regulate_enable;
      impulse <= '0;
      count   <= '0;
      high    <= '0;
      low     <= '0;
    end
    if (cmd.mul_load) prod <= prod_next;
    if (cmd.integ_update) acc <= 34'(isum_sat);
    if (cmd.acc_add) acc <= acc + 34'(prod);
    if (cmd.div_load) begin
      dprod   <= pvp_pkg::DPROD_W'(mag) * pvp_pkg::DPROD_W'(pvp_pkg::RECIP_KILO);
      acc_neg <= acc_clamp[pvp_pkg::ACC_W-1];
    end
    if (cmd.cso_load) cso <= 17'(cycle_s) * 17'(opening);
    if (cmd.rec_load) rprod <= pvp_pkg::RPROD_W'(rec_a) * pvp_pkg::RPROD_W'(rec_m);
    if (cmd.imp_load) impulse <= status.imp_ok ? rec_q[pvp_pkg::MS_W-1:0] : '0;
    if (cmd.n_init) n <= pvp_pkg::N_W'(pvp_pkg::MAX_PULSES);
    if (cmd.n_dec) n <= n - 1'b1;
    if (cmd.high_load) high <= rec_q[pvp_pkg::MS_W-1:0];
    // high * n never exceeds the impulse, so the pause stays positive
    if (cmd.rem_load) rem <= 14'(18'(span) - high_n);
    if (cmd.low_load) begin
      low   <= rec_q[pvp_pkg::MS_W-1:0];
      count <= n;
    end
    if (cmd.fallback) begin
      count <= pvp_pkg::N_W'(1);
      high  <= impulse;
      low   <= span - impulse;
    end
    if (cmd.out_load) begin
      out_pid  <= pid_out;
      out_pct  <= opening;
      out_imp  <= impulse;
      out_cnt  <= pvp_pkg::CNT_OUT_W'(count);
      out_high <= high;
      out_low  <= low;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    status.op       = op_q;
    status.enable   = en_q;
    status.imp_ok   = rec_q > 18'(pvp_pkg::ONE_MIN_MS);
    status.high_ok  = high > 14'(pvp_pkg::PACK_MIN_MS);
    status.low_ok   = rec_q > 18'(pvp_pkg::PACK_MIN_MS);
    status.n_last   = (n == pvp_pkg::N_W'(1));
    status.out_free = !out_valid || out_ready;
  end

  assign pid_value     = out_pid;
  assign valve_percent = out_pct;
  assign impulse_ms    = out_imp;
  assign pulse_count   = out_cnt;
  assign pulse_high_ms = out_high;
  assign pulse_low_ms  = out_low;

endmodule

@@ hw/rtl/ph_pid_valve_pulse_planner.sv @@
// ----------------------------------------------------------------------------
// ph_pid_valve_pulse_planner
// pH PID regulator with valve dosing planner: sequencer plus datapath.
// ----------------------------------------------------------------------------
// Start, stop and disabled items go straight to the output register. A PID sample
// steps through integral, P and D terms, divide and output; a dosing cycle tries
// pulse counts from MAX_PULSES downward, using the shared reciprocal multiplier.
// One item in flight; the next is taken the cycle after its result is stored
// in the output register. Reset restores register defaults and regulator state.
// ----------------------------------------------------------------------------
module ph_pid_valve_pulse_planner (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pvp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pvp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        op,
  input  logic [pvp_pkg::PH_W-1:0]          measured_ph,
  input  logic [pvp_pkg::PCT_W-1:0]         start_percent,
  input  logic                              regulate_enable,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pvp_pkg::PID_W-1:0]  pid_value,
  output logic [pvp_pkg::PCT_W-1:0]         valve_percent,
  output logic [pvp_pkg::MS_W-1:0]          impulse_ms,
  output logic [pvp_pkg::CNT_OUT_W-1:0]     pulse_count,
  output logic [pvp_pkg::MS_W-1:0]          pulse_high_ms,
  output logic [pvp_pkg::MS_W-1:0]          pulse_low_ms
);

  pvp_pkg::pvp_cmd_t    cmd;
  pvp_pkg::pvp_status_t status;

  pvp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pvp_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .op              (op),
    .measured_ph     (measured_ph),
    .start_percent   (start_percent),
    .regulate_enable (regulate_enable),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .pid_value       (pid_value),
    .valve_percent   (valve_percent),
    .impulse_ms      (impulse_ms),
    .pulse_count     (pulse_count),
    .pulse_high_ms   (pulse_high_ms),
    .pulse_low_ms    (pulse_low_ms)
  );

endmodule
